### design/stable_sorted_priority_queue_unit_defines.svh
// Assertion macros for the stable sorted priority queue unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every edge outside reset.
`define SSPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every edge, reset included.
`define SSPQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSPQ_ASSERT(name, prop, msg)
`define SSPQ_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### design/sspq_pkg.sv
// Types and codes for the stable sorted priority queue unit.
// Used by sspq_cell and stable_sorted_priority_queue_unit; no dependencies.
`default_nettype none

package sspq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_NOP    = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  priority_req;
        logic [15:0] reg_number;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  front_priority;
        logic [15:0] front_reg_number;
        logic [4:0]  entry_count;
        logic        is_empty;
    } out_item_t;

    // One slot of the queue as seen by its neighbors.
    typedef struct packed {
        logic        valid;
        logic [3:0]  prio;
        logic [15:0] reg_number;
    } entry_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic        insert;
        logic        remove;
        logic [3:0]  new_prio;
        logic [15:0] new_reg_number;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### design/sspq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on sspq_pkg.
`default_nettype none

module sspq_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sspq_pkg::cell_ctrl_t  ctrl,
    input  wire sspq_pkg::entry_t      left_entry,
    input  wire logic                  left_lower,
    input  wire sspq_pkg::entry_t      right_entry,
    output sspq_pkg::entry_t           entry,
    output logic                       lower
);
    import sspq_pkg::*;

    logic        valid_reg, valid_next;
    logic [3:0]  prio_reg, prio_next;
    logic [15:0] reg_number_reg, reg_number_next;

    // Empty slots and strictly lower priorities give way to the new entry.
    assign lower = !valid_reg || (prio_reg < ctrl.new_prio);

    assign entry.valid      = valid_reg;
    assign entry.prio       = prio_reg;
    assign entry.reg_number = reg_number_reg;

    always_comb
    begin
        valid_next      = valid_reg;
        prio_next       = prio_reg;
        reg_number_next = reg_number_reg;
        if (ctrl.insert)
        begin
            valid_next = valid_reg || left_entry.valid;
            if (lower)
            begin
                if (left_lower)
                begin
                    // left neighbor also gives way: take its entry
                    prio_next       = left_entry.prio;
                    reg_number_next = left_entry.reg_number;
                end
                else
                begin
                    prio_next       = ctrl.new_prio;
                    reg_number_next = ctrl.new_reg_number;
                end
            end
        end
        else if (ctrl.remove)
        begin
            valid_next      = right_entry.valid;
            prio_next       = right_entry.prio;
            reg_number_next = right_entry.reg_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg       <= prio_next;
        reg_number_reg <= reg_number_next;
    end

endmodule

`default_nettype wire

### design/stable_sorted_priority_queue_unit.sv
// Top level of the stable sorted priority queue: a row of sspq_cell slots and a result register.
// Depends on sspq_pkg, sspq_cell and stable_sorted_priority_queue_unit_defines.svh.
`default_nettype none

// Bounded priority queue of CAPACITY entries (2 to 256) kept sorted in a row of cells,
// slot 0 the front; higher priority leaves first and equal priorities leave in arrival
// order. For every command (insert, remove, peek) all cells compare the new priority in
// parallel and shift in the same clock, so the queue accepts one beat per cycle, and the
// result beat appears in the output register in the cycle after acceptance.
// A new beat is taken while the previous result is being taken; the rate drops only when
// the output side stalls. entry_count carries the low 5 bits of the held count.

`include "stable_sorted_priority_queue_unit_defines.svh"

module stable_sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sspq_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sspq_pkg::out_item_t      out_data
);
    import sspq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    out_item_t        out_data_reg, out_data_next;

    cell_ctrl_t       ctrl;
    entry_t           cell_entry [CAPACITY];
    logic             cell_lower [CAPACITY];
    logic             accept;
    logic             full;
    logic             empty;
    logic [31:0]      count_wide;
    logic             sorted_ok;
    logic [CAPACITY-1:0] valid_vec;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign ctrl.insert         = accept && (in_data.command == CMD_INSERT) && !full;
    assign ctrl.remove         = accept && (in_data.command == CMD_REMOVE) && !empty;
    assign ctrl.new_prio       = in_data.priority_req;
    assign ctrl.new_reg_number = in_data.reg_number;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_l;

            if (i == 0)
            begin : g_head
                // front slot: the new entry arrives from here
                assign left_e = '{valid: 1'b1, prio: 4'd0, reg_number: 16'd0};
                assign left_l = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[i-1];
                assign left_l = cell_lower[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_next
                assign right_e = cell_entry[i+1];
            end

            sspq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_e),
                .left_lower  (left_l),
                .right_entry (right_e),
                .entry       (cell_entry[i]),
                .lower       (cell_lower[i])
            );

            assign valid_vec[i] = cell_entry[i].valid;
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_wide = 32'(count_next);

    always_comb
    begin
        out_data_next.status           = ST_OK;
        out_data_next.front_priority   = 4'd0;
        out_data_next.front_reg_number = 16'd0;
        case (in_data.command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    out_data_next.status = ST_FULL;
                end
            end
            CMD_REMOVE, CMD_PEEK:
            begin
                if (empty)
                begin
                    out_data_next.status = ST_EMPTY;
                end
                else
                begin
                    out_data_next.front_priority   = cell_entry[0].prio;
                    out_data_next.front_reg_number = cell_entry[0].reg_number;
                end
            end
            default:
            begin
                out_data_next.status = ST_OK;
            end
        endcase
        out_data_next.entry_count = count_wide[4:0];
        out_data_next.is_empty    = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Held entries must stay in non-increasing priority order.
    always_comb
    begin
        sorted_ok = 1'b1;
        for (int k = 1; k < CAPACITY; k++)
        begin
            if (cell_entry[k].valid &&
                (!cell_entry[k-1].valid || (cell_entry[k].prio > cell_entry[k-1].prio)))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    `SSPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SSPQ_ASSERT_ALWAYS(a_valid_matches_count,
        $countones(valid_vec) == 32'(count_reg),
        "slot valid bits disagree with count")
    `SSPQ_ASSERT(a_sorted, sorted_ok, "queue slots out of priority order")
    `SSPQ_ASSERT(a_full_reject,
        (accept && (in_data.command == CMD_INSERT) && full) |=>
            (out_data.status == ST_FULL) && (count_reg == $past(count_reg)),
        "insert into full queue not rejected")
    `SSPQ_ASSERT(a_remove_count,
        (accept && (in_data.command == CMD_REMOVE) && !empty) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)),
        "remove did not drop count")

endmodule

`default_nettype wire
